// ===== rtl/function_word_absence_detector_top_defines.svh =====
// Assertion macros for the function word absence detector.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FUNCTION_WORD_ABSENCE_DETECTOR_TOP_DEFINES_SVH
`define FUNCTION_WORD_ABSENCE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define FWAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define FWAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fwad_pkg.sv =====
// Shared types, constants and the function word table of the detector.
// No dependencies; every other file but the assertion macros header refers to it by scoped names.
`default_nettype none

package fwad_pkg;

	localparam int CHAR_W      = 8;
	localparam int WORD_CHARS  = 6;
	localparam int WORD_BITS   = CHAR_W * WORD_CHARS;
	localparam int TOO_LONG    = WORD_CHARS + 1;
	localparam int CNT_W       = $clog2(TOO_LONG + 1);
	localparam int LEN_W       = 3;
	localparam int WCNT_W      = 4;
	localparam int COUNT_MAX   = 15;
	localparam int TABLE_WORDS = 64;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_MIN_LEN   = 1'b0;
	localparam logic REG_MIN_COUNT = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_APOS  = 8'h27;
	localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;
	localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'h20;

	typedef logic [WORD_BITS-1:0] word_t;

	// One classified byte as it travels from front to back
	typedef struct packed {
		logic              is_letter;
		logic [CHAR_W-1:0] letter;
		logic              is_delim;
		logic              eot;
	} ev_t;

	typedef struct packed {
		logic [LEN_W-1:0]  min_len;
		logic [WCNT_W-1:0] min_count;
	} cfg_t;

	// Words are packed with the first letter highest and zero padding above,
	// so a string literal zero-extended to the word width lines up directly.
	localparam word_t FW_TABLE [TABLE_WORDS] = '{
		48'("the"),   48'("a"),     48'("an"),    48'("of"),    48'("to"),
		48'("and"),   48'("in"),    48'("is"),    48'("are"),   48'("was"),
		48'("were"),  48'("that"),  48'("this"),  48'("it"),    48'("for"),
		48'("with"),  48'("as"),    48'("on"),    48'("at"),    48'("by"),
		48'("be"),    48'("been"),  48'("from"),  48'("or"),    48'("not"),
		48'("you"),   48'("we"),    48'("they"),  48'("he"),    48'("she"),
		48'("his"),   48'("her"),   48'("its"),   48'("their"), 48'("our"),
		48'("my"),    48'("i"),     48'("but"),   48'("if"),    48'("so"),
		48'("then"),  48'("than"),  48'("which"), 48'("who"),   48'("what"),
		48'("when"),  48'("where"), 48'("how"),   48'("all"),   48'("any"),
		48'("can"),   48'("will"),  48'("would"), 48'("should"), 48'("may"),
		48'("might"), 48'("there"), 48'("here"),  48'("do"),    48'("does"),
		48'("did"),   48'("have"),  48'("has"),   48'("had")
	};

	// Parallel compare against every table entry
	function automatic logic in_table(input word_t w);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			hit = hit | (w == FW_TABLE[i]);
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fwad_channels.sv =====
// Handshake channel interfaces: text bytes in, verdicts out.
// Depends on fwad_pkg for field widths.
`default_nettype none

interface fwad_in_if;
	logic                      valid;
	logic                      ready;
	logic [fwad_pkg::CHAR_W-1:0] char_code;
	logic                      has_char;
	logic                      end_of_text;

	modport source(output valid, char_code, has_char, end_of_text, input ready);
	modport sink(input valid, char_code, has_char, end_of_text, output ready);
endinterface

interface fwad_out_if;
	logic                        valid;
	logic                        ready;
	logic                        no_function_word;
	logic [fwad_pkg::WCNT_W-1:0] word_count;

	modport source(output valid, no_function_word, word_count, input ready);
	modport sink(input valid, no_function_word, word_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwad_front.sv =====
// Front end: accepts text bytes, folds case and classifies each byte.
// Depends on fwad_pkg and fwad_in_if; feeds the event queue.
`default_nettype none

module fwad_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	fwad_in_if.sink              text_in,
	output logic                 push,
	output fwad_pkg::ev_t        push_ev,
	input  wire logic            q_full
);

	logic          valid_s1;
	fwad_pkg::ev_t ev_s1;
	fwad_pkg::ev_t ev_c;
	logic          accept;
	logic          upper;
	logic          lower;

	// Take a new beat whenever the stage is empty or drains this cycle
	assign text_in.ready = !valid_s1 || !q_full;
	assign accept        = text_in.valid && text_in.ready;
	assign push          = valid_s1 && !q_full;
	assign push_ev       = ev_s1;

	// Classify the byte: letter (folded to lower case), apostrophe, or word break
	always_comb begin
		upper = (text_in.char_code >= fwad_pkg::CHAR_UP_A) &&
			(text_in.char_code <= fwad_pkg::CHAR_UP_Z);
		lower = (text_in.char_code >= fwad_pkg::CHAR_LO_A) &&
			(text_in.char_code <= fwad_pkg::CHAR_LO_Z);
		ev_c.is_letter = text_in.has_char &&
			(upper || lower || text_in.char_code == fwad_pkg::CHAR_APOS);
		ev_c.letter    = upper ? (text_in.char_code + fwad_pkg::CASE_SHIFT)
			: text_in.char_code;
		ev_c.is_delim  = text_in.has_char && !ev_c.is_letter;
		ev_c.eot       = text_in.end_of_text;
	end

	// Hold the classified beat; drop beats that carry neither byte nor end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= text_in.has_char || text_in.end_of_text;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fwad_queue.sv =====
// Short event queue between front and back end.
// Depends on fwad_pkg for the event type and depth.
`default_nettype none

module fwad_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  fwad_pkg::ev_t       push_ev,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output fwad_pkg::ev_t       head_ev
);

	fwad_pkg::ev_t                 mem_q [fwad_pkg::FIFO_DEPTH];
	logic [fwad_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [fwad_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [fwad_pkg::FCNT_W-1:0]  fill_q;

	assign full       = (fill_q == fwad_pkg::FCNT_W'(fwad_pkg::FIFO_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_ev    = mem_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fwad_back.sv =====
// Back end: assembles words, matches them against the table and counts them,
// then registers one verdict per text. Depends on fwad_pkg and fwad_out_if.
`default_nettype none

module fwad_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  fwad_pkg::cfg_t       cfg,
	input  wire logic            head_valid,
	input  fwad_pkg::ev_t        head_ev,
	output logic                 pop,
	fwad_out_if.source           verdict_out
);

	fwad_pkg::word_t               word_q;
	logic [fwad_pkg::CNT_W-1:0]    cnt_q;
	logic [fwad_pkg::WCNT_W-1:0]   words_q;
	logic                          saw_q;
	logic                          out_valid_q;
	logic                          nfw_q;
	logic [fwad_pkg::WCNT_W-1:0]   count_q;

	fwad_pkg::word_t               word_n;
	logic [fwad_pkg::CNT_W-1:0]    cnt_n;
	logic [fwad_pkg::LEN_W-1:0]    need;
	logic                          close;
	logic                          counted;
	logic                          hit;
	logic [fwad_pkg::WCNT_W-1:0]   words_n;
	logic                          saw_n;
	logic                          verdict;

	// Pop unless a verdict is due and the output slot is still occupied
	assign pop = head_valid &&
		(!head_ev.eot || !out_valid_q || verdict_out.ready);

	assign verdict_out.valid            = out_valid_q;
	assign verdict_out.no_function_word = nfw_q;
	assign verdict_out.word_count       = count_q;

	// Append the letter, then close the word on a break or at end of text
	always_comb begin
		word_n = word_q;
		cnt_n  = cnt_q;
		if (head_ev.is_letter) begin
			if (int'(cnt_q) < fwad_pkg::WORD_CHARS) begin
				word_n = {word_q[fwad_pkg::WORD_BITS-fwad_pkg::CHAR_W-1:0],
					head_ev.letter};
			end
			if (int'(cnt_q) < fwad_pkg::TOO_LONG) begin
				cnt_n = cnt_q + 1'b1;
			end
		end
		close   = head_ev.is_delim || head_ev.eot;
		need    = (cfg.min_len == '0) ? fwad_pkg::LEN_W'(1) : cfg.min_len;
		counted = close && (int'(cnt_n) >= int'(need));
		hit     = counted && (cnt_n != '0) &&
			(int'(cnt_n) <= fwad_pkg::WORD_CHARS) && fwad_pkg::in_table(word_n);
		words_n = (counted && int'(words_q) < fwad_pkg::COUNT_MAX) ?
			words_q + 1'b1 : words_q;
		saw_n   = saw_q || hit;
		verdict = (words_n >= cfg.min_count) && !saw_n;
	end

	// Hold word and text state; clear after each closed word and each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			cnt_q   <= '0;
			words_q <= '0;
			saw_q   <= 1'b0;
		end else if (pop) begin
			if (close) begin
				word_q <= '0;
				cnt_q  <= '0;
			end else begin
				word_q <= word_n;
				cnt_q  <= cnt_n;
			end
			if (head_ev.eot) begin
				words_q <= '0;
				saw_q   <= 1'b0;
			end else begin
				words_q <= words_n;
				saw_q   <= saw_n;
			end
		end
	end

	// Output slot: drop on handshake, load on a verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_ev.eot) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_ev.eot) begin
			nfw_q   <= verdict;
			count_q <= words_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/function_word_absence_detector_top.sv =====
// Function word absence detector. Text enters one byte per beat on text_in; letters
// and apostrophes form words, case folded, and any other byte or the end of text ends
// a word. Words at least min_word_length long are counted (saturating at 15) and
// compared with a table of 64 English function words. On the last beat of a text one
// verdict leaves on verdict_out: no_function_word is 1 when word_count reaches
// min_word_count and no counted word was in the table. A beat is taken every cycle
// unless the front stage is held by a full queue; the rate is set by the back end, which
// closes and matches one word per cycle unless a verdict is stalled, and a four-entry
// queue lets bytes keep flowing while a verdict waits to be taken.
// Registers via APB: min_word_length at 0x0 (reset 2), min_word_count at 0x4
// (reset 4); write them only while no text is in flight.
// Depends on fwad_pkg, fwad_channels, fwad_front, fwad_queue and fwad_back.
`default_nettype none

module function_word_absence_detector_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fwad_in_if.sink                              text_in,
	fwad_out_if.source                           verdict_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fwad_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [fwad_pkg::PDATA_W-1:0]    pwdata,
	output logic      [fwad_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready
);

	fwad_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic           push;
	fwad_pkg::ev_t  push_ev;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	fwad_pkg::ev_t  head_ev;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_len   <= fwad_pkg::LEN_W'(2);
			cfg_q.min_count <= fwad_pkg::WCNT_W'(4);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fwad_pkg::REG_MIN_LEN:   cfg_q.min_len   <= pwdata[fwad_pkg::LEN_W-1:0];
				fwad_pkg::REG_MIN_COUNT: cfg_q.min_count <= pwdata[fwad_pkg::WCNT_W-1:0];
				default:                 cfg_q           <= cfg_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			fwad_pkg::REG_MIN_LEN:   prdata = fwad_pkg::PDATA_W'(cfg_q.min_len);
			fwad_pkg::REG_MIN_COUNT: prdata = fwad_pkg::PDATA_W'(cfg_q.min_count);
			default:                 prdata = '0;
		endcase
	end

	fwad_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.push    (push),
		.push_ev (push_ev),
		.q_full  (q_full)
	);

	fwad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ev    (push_ev),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ev    (head_ev)
	);

	fwad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_ev     (head_ev),
		.pop         (pop),
		.verdict_out (verdict_out)
	);

endmodule

`default_nettype wire

// ===== rtl/fwad_checker.sv =====
// Port-level checks of the detector, bound to the top level.
// Depends on fwad_pkg and the assertion macros header.
`default_nettype none
`include "function_word_absence_detector_top_defines.svh"

module fwad_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          out_nfw,
	input  wire logic [fwad_pkg::WCNT_W-1:0]   out_count,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fwad_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [fwad_pkg::PDATA_W-1:0]  pwdata,
	input  wire logic [fwad_pkg::PDATA_W-1:0]  prdata,
	input  wire logic                          pready
);

	// Port never inserts wait states
	`FWAD_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready dropped")

	// A stalled verdict stays offered
	`FWAD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "verdict withdrawn")

	// A stalled verdict keeps its value
	`FWAD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_nfw) && $stable(out_count), "verdict changed while stalled")

	// A length write reads back on the next cycle
	`FWAD_ASSERT_IMP(a_len_readback, $past(arst_n) && $past(psel && penable && pwrite && pready) && ($past(paddr[2]) == fwad_pkg::REG_MIN_LEN) && (paddr[2] == fwad_pkg::REG_MIN_LEN), prdata[fwad_pkg::LEN_W-1:0] == $past(pwdata[fwad_pkg::LEN_W-1:0]), "min length readback mismatch")

endmodule

bind function_word_absence_detector_top fwad_checker u_fwad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (verdict_out.valid),
	.out_ready (verdict_out.ready),
	.out_nfw   (verdict_out.no_function_word),
	.out_count (verdict_out.word_count),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);

`default_nettype wire
